// ===== hdl/cupd_pkg.sv =====
// Shared types and constants for the capture register block.
// Depends on nothing; imported by every other file of the block except cupd_if.
`timescale 1ns / 1ps

package cupd_pkg;

	// register file geometry
	localparam int REG_WORDS = 64;
	localparam int REG_AW    = $clog2(REG_WORDS);

	// default capture limits
	localparam int MAX_LINE_BYTES_DEF = 8192;
	localparam int MAX_LINES_DEF      = 4096;

	// word indexes of the registers with behaviour of their own
	localparam logic [REG_AW-1:0] W_START  = REG_AW'(0);
	localparam logic [REG_AW-1:0] W_CYCLE  = REG_AW'(3);
	localparam logic [REG_AW-1:0] W_CWIDTH = REG_AW'(5);
	localparam logic [REG_AW-1:0] W_STRIDE = REG_AW'(14);
	localparam logic [REG_AW-1:0] W_DEST   = REG_AW'(15);
	localparam logic [REG_AW-1:0] W_EVENT  = REG_AW'(29);
	localparam logic [REG_AW-1:0] W_STATUS = REG_AW'(31);
	localparam logic [REG_AW-1:0] W_COUNT  = REG_AW'(33);

	localparam logic [31:0] START_MASK     = 32'h0000_0001;
	localparam logic [31:0] SRST_MASK      = 32'h0001_0000;
	localparam logic [31:0] FRAME_END_MASK = 32'h0000_0001;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_TICK  = 2'd2
	} kind_t;

	// request strobes from the top level to the capture engine
	typedef struct packed {
		logic start;
		logic abort;
		logic tick;
	} cap_ctrl_t;

	// register fields the capture engine latches on start
	typedef struct packed {
		logic [12:0] stride;
		logic [31:0] cycle;
		logic [11:0] lines;
		logic [31:0] dest;
	} cap_geo_t;

	// one capture beat, all fields but count zero when valid is low
	typedef struct packed {
		logic        valid;
		logic [32:0] addr;
		logic [7:0]  pattern;
		logic        last;
		logic [31:0] count;
	} cap_beat_t;

	// words held in flip-flops in the top level rather than in the RAM
	function automatic logic is_ctrl_word(input logic [REG_AW-1:0] w);
		logic r;
		begin
			r = (w == W_START) || (w == W_CYCLE) || (w == W_CWIDTH) || (w == W_STRIDE) ||
				(w == W_DEST) || (w == W_EVENT) || (w == W_COUNT);
			return r;
		end
	endfunction

endpackage

// ===== hdl/cupd_if.sv =====
// Valid/ready channel interfaces for the capture register block.
// Depends on nothing.
`timescale 1ns / 1ps

interface cupd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  offset;
	logic [31:0] wdata;

	modport source (output valid, output kind, output offset, output wdata, input ready);
	modport sink (input valid, input kind, input offset, input wdata, output ready);
endinterface

interface cupd_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] rdata;
	logic        mem_valid;
	logic [32:0] mem_addr;
	logic [7:0]  mem_byte;
	logic        frame_done;

	modport source (output valid, output rdata, output mem_valid, output mem_addr,
		output mem_byte, output frame_done, input ready);
	modport sink (input valid, input rdata, input mem_valid, input mem_addr,
		input mem_byte, input frame_done, output ready);
endinterface

// ===== hdl/capture_unit_pattern_dma_unit.sv =====
// Top level of the capture register block: register decode, control words, result register.
// Depends on cupd_pkg, cupd_if, cupd_regfile and cupd_capture.
`timescale 1ns / 1ps
//
//  channel | dir | transfer carries
//  --------+-----+---------------------------------------------------
//  req     | in  | kind, offset, wdata  (read, write or capture tick)
//  rsp     | out | rdata, mem_valid, mem_addr, mem_byte, frame_done
//
//  Every request transfer produces exactly one response transfer, from the response register.
//  One request is taken per cycle; the response register frees itself in the
//  cycle it is taken, so req.ready is low only while a response waits unclaimed.
//  The frame address advances by one add per tick; line offsets are accumulated,
//  so no multiplier sits in the tick path.
//  arst_n clears the register file (through valid bits), the control words and
//  the capture engine at once; no clearing pass is needed.

module capture_unit_pattern_dma_unit #(
	parameter int MAX_LINE_BYTES = cupd_pkg::MAX_LINE_BYTES_DEF,
	parameter int MAX_LINES      = cupd_pkg::MAX_LINES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	cupd_req_if.sink    req,
	cupd_rsp_if.source  rsp
);
	import cupd_pkg::*;

	// control words kept in flip-flops
	logic [31:0] start_q;
	logic [31:0] cycle_q;
	logic [31:0] cwidth_q;
	logic [31:0] stride_q;
	logic [31:0] dest_q;
	logic [31:0] event_q;
	logic [31:0] count_q;

	// response register
	logic        out_valid_q;
	logic        rd_mem_q;
	logic [31:0] rdata_q;
	logic        mem_valid_q;
	logic [32:0] mem_addr_q;
	logic [7:0]  mem_byte_q;
	logic        frame_done_q;

	logic              accept;
	logic [REG_AW-1:0] word;
	logic              ctrl_word;
	logic              wr;
	logic              rd;
	logic              tick;
	logic              wr_start;
	logic              srst;
	logic              mem_we;
	logic              mem_re;
	logic [31:0]       mem_rdata;
	logic [31:0]       ctrl_rdata;
	logic              busy;
	cap_ctrl_t         cap_ctrl;
	cap_geo_t          cap_geo;
	cap_beat_t         beat;

	// a new transfer is taken whenever the response slot is free or being emptied
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// low two offset bits are ignored
	assign word      = req.offset[7:2];
	assign ctrl_word = is_ctrl_word(word);

	always_comb begin
		wr   = 1'b0;
		rd   = 1'b0;
		tick = 1'b0;
		case (req.kind)
			KIND_READ:  rd   = accept;
			KIND_WRITE: wr   = accept;
			KIND_TICK:  tick = accept;
			default: ;
		endcase
	end

	assign wr_start = wr && (word == W_START);
	assign srst     = wr_start && ((req.wdata & SRST_MASK) != 32'd0);

	// soft reset wins over start when both bits are written
	assign cap_ctrl.start = wr_start && !srst && ((req.wdata & START_MASK) != 32'd0);
	assign cap_ctrl.abort = srst;
	assign cap_ctrl.tick  = tick;

	assign cap_geo.stride = stride_q[12:0];
	assign cap_geo.cycle  = cycle_q;
	assign cap_geo.lines  = cwidth_q[27:16];
	assign cap_geo.dest   = dest_q;

	// every other word lives in the RAM; status always reads zero so skip its read
	assign mem_we = wr && !ctrl_word;
	assign mem_re = rd && !ctrl_word && (word != W_STATUS);

	cupd_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (word),
		.wdata  (req.wdata),
		.re     (mem_re),
		.raddr  (word),
		.rdata  (mem_rdata)
	);

	cupd_capture #(
		.MAX_LINE_BYTES (MAX_LINE_BYTES),
		.MAX_LINES      (MAX_LINES)
	) u_capture (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cap_ctrl),
		.geo    (cap_geo),
		.beat   (beat),
		.busy   (busy)
	);

	// read mux for the flip-flop words; hide the soft-reset bit of the start word
	always_comb begin
		unique case (word)
			W_START:  ctrl_rdata = start_q & ~SRST_MASK;
			W_CYCLE:  ctrl_rdata = cycle_q;
			W_CWIDTH: ctrl_rdata = cwidth_q;
			W_STRIDE: ctrl_rdata = stride_q;
			W_DEST:   ctrl_rdata = dest_q;
			W_EVENT:  ctrl_rdata = event_q;
			W_COUNT:  ctrl_rdata = count_q;
			default:  ctrl_rdata = 32'd0;
		endcase
	end

	// control word updates: register writes first, frame end on top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			cycle_q  <= '0;
			cwidth_q <= '0;
			stride_q <= '0;
			dest_q   <= '0;
			event_q  <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				unique case (word)
					W_START:  start_q  <= srst ? (req.wdata & ~(SRST_MASK | START_MASK))
						: req.wdata;
					W_CYCLE:  cycle_q  <= req.wdata;
					W_CWIDTH: cwidth_q <= req.wdata;
					W_STRIDE: stride_q <= req.wdata;
					W_DEST:   dest_q   <= req.wdata;
					W_EVENT:  event_q  <= req.wdata;
					W_COUNT:  count_q  <= req.wdata;
					default: ;
				endcase
			end
			if (srst) begin
				event_q <= '0;
			end
			// latch frame end, byte count and drop the start bit
			if (beat.last) begin
				event_q <= event_q | FRAME_END_MASK;
				count_q <= beat.count;
				start_q <= start_q & ~START_MASK;
			end
		end
	end

	// response register: load on every accepted transfer, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			rd_mem_q     <= 1'b0;
			mem_valid_q  <= 1'b0;
			frame_done_q <= 1'b0;
		end else if (accept) begin
			out_valid_q  <= 1'b1;
			rd_mem_q     <= mem_re;
			mem_valid_q  <= beat.valid;
			frame_done_q <= beat.last;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q    <= rd ? ctrl_rdata : 32'd0;
			mem_addr_q <= beat.addr;
			mem_byte_q <= beat.pattern;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.rdata      = rdata_q | (rd_mem_q ? mem_rdata : 32'd0);
	assign rsp.mem_valid  = mem_valid_q;
	assign rsp.mem_addr   = mem_addr_q;
	assign rsp.mem_byte   = mem_byte_q;
	assign rsp.frame_done = frame_done_q;

`ifndef ASSERT_OFF
	a_done_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_done_q |-> mem_valid_q)
		else $error("frame_done without a frame-buffer byte");

	a_srst_aborts: assert property (@(posedge clk) disable iff (!arst_n)
		srst |=> !busy)
		else $error("capture still busy after soft reset");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_done_q |-> !busy && ((start_q & START_MASK) == 32'd0))
		else $error("capture or start bit still set after frame end");

	a_byte_no_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && mem_valid_q |-> rsp.rdata == 32'd0)
		else $error("read data on a capture beat");
`endif

endmodule

// ===== hdl/cupd_regfile.sv =====
// General-purpose register words: RAM with a write port, a read port and per-word valid bits.
// Depends on cupd_pkg.
`timescale 1ns / 1ps

module cupd_regfile (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [cupd_pkg::REG_AW-1:0] waddr,
	input  logic [31:0]                wdata,
	input  logic                       re,
	input  logic [cupd_pkg::REG_AW-1:0] raddr,
	output logic [31:0]                rdata
);
	import cupd_pkg::*;

	logic [31:0]          mem [REG_WORDS];
	logic [REG_WORDS-1:0] vld_q;
	logic [31:0]          rd_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// unwritten words read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : 32'd0;

endmodule

// ===== hdl/cupd_capture.sv =====
// Capture engine: latches frame geometry on start and walks the frame one byte per tick.
// Depends on cupd_pkg.
`timescale 1ns / 1ps

module cupd_capture #(
	parameter int MAX_LINE_BYTES = cupd_pkg::MAX_LINE_BYTES_DEF,
	parameter int MAX_LINES      = cupd_pkg::MAX_LINES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cupd_pkg::cap_ctrl_t  ctrl,
	input  cupd_pkg::cap_geo_t   geo,
	output cupd_pkg::cap_beat_t  beat,
	output logic                 busy
);
	import cupd_pkg::*;

	localparam int WW = $clog2(MAX_LINE_BYTES + 1);
	localparam int HW = $clog2(MAX_LINES + 1);
	localparam int BW = WW + HW;

	logic          busy_q;
	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [WW-1:0] col_q;
	logic [HW-1:0] line_q;
	logic [32:0]   row_addr_q;
	logic [BW-1:0] line_base_q;

	logic [13:0]   w_sel;
	logic [13:0]   h_sel;
	logic [WW-1:0] w_clamp;
	logic [HW-1:0] h_clamp;
	logic          go;
	logic          active;
	logic [WW:0]   col_inc;
	logic [HW:0]   line_inc;
	logic          line_end;
	logic          frame_end;

	// stride wins over the cycle field, capture width over the cycle line field
	always_comb begin
		w_sel   = (geo.stride != 13'd0) ? {1'b0, geo.stride} : geo.cycle[13:0];
		h_sel   = (geo.lines != 12'd0) ? {2'b0, geo.lines} : geo.cycle[29:16];
		w_clamp = (32'(w_sel) > 32'(MAX_LINE_BYTES)) ? WW'(MAX_LINE_BYTES) : WW'(w_sel);
		h_clamp = (32'(h_sel) > 32'(MAX_LINES)) ? HW'(MAX_LINES) : HW'(h_sel);
		go      = ctrl.start && (w_sel != 14'd0) && (h_sel != 14'd0) && (geo.dest != 32'd0);
	end

	always_comb begin
		active    = ctrl.tick && busy_q;
		col_inc   = {1'b0, col_q} + (WW+1)'(1);
		line_inc  = {1'b0, line_q} + (HW+1)'(1);
		line_end  = col_inc >= {1'b0, width_q};
		frame_end = line_end && (line_inc >= {1'b0, height_q});
	end

	always_comb begin
		beat.valid   = active;
		beat.addr    = active ? (row_addr_q + 33'(col_q)) : 33'd0;
		beat.pattern = active ? 8'(32'(col_q) + 32'(line_q)) : 8'd0;
		beat.last    = active && frame_end;
		beat.count   = 32'(line_base_q) + 32'(width_q);
	end

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= '0;
			line_q <= '0;
		end else if (ctrl.abort) begin
			busy_q <= 1'b0;
		end else if (go) begin
			busy_q <= 1'b1;
			col_q  <= '0;
			line_q <= '0;
		end else if (active) begin
			if (line_end) begin
				col_q <= '0;
				if (frame_end) begin
					busy_q <= 1'b0;
					line_q <= '0;
				end else begin
					line_q <= line_inc[HW-1:0];
				end
			end else begin
				col_q <= col_inc[WW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!ctrl.abort && go) begin
			width_q     <= w_clamp;
			height_q    <= h_clamp;
			row_addr_q  <= {1'b0, geo.dest};
			line_base_q <= '0;
		end else if (!ctrl.abort && active && line_end) begin
			row_addr_q  <= row_addr_q + 33'(width_q);
			line_base_q <= line_base_q + BW'(width_q);
		end
	end

endmodule

// ===== sim/capture_checker.sv =====
// Checker for the capture register block: predicts each response from the request stream
// and compares it with the response transfers. Depends on cupd_pkg and cupd_if.
`timescale 1ns / 1ps

module capture_checker (
	input  logic clk,
	input  logic arst_n,
	cupd_req_if  req,
	cupd_rsp_if  rsp,
	output int   errors,
	output int   pending,
	output int   frames
);
	import cupd_pkg::*;

	localparam int REPORT_CAP = 40;

	typedef struct packed {
		logic [31:0] rdata;
		logic        mem_valid;
		logic [32:0] mem_addr;
		logic [7:0]  mem_byte;
		logic        frame_done;
	} capture_result_t;

	// predicted register file and capture engine
	logic [31:0] reg_file [REG_WORDS];
	logic        busy;
	logic [13:0] col;
	logic [12:0] line;
	logic [13:0] width;
	logic [12:0] height;
	logic [31:0] base;

	capture_result_t due_results [$];
	capture_result_t head;
	capture_result_t fresh;
	int err_cnt;
	int frame_cnt;

	function automatic capture_result_t predict_result(input logic [1:0] kind,
			input logic [7:0] offset, input logic [31:0] wdata);
		capture_result_t r;
		logic [REG_AW-1:0] word;
		logic [13:0] w;
		logic [13:0] h;
		logic [63:0] addr;
		r = '0;
		word = offset[7:2];
		case (kind)
			KIND_READ: begin
				if (word == W_STATUS)
					r.rdata = '0;
				else if (word == W_START)
					r.rdata = reg_file[word] & ~SRST_MASK;
				else
					r.rdata = reg_file[word];
			end
			KIND_WRITE: begin
				reg_file[word] = wdata;
				if (word == W_START) begin
					if ((wdata & SRST_MASK) != '0) begin
						reg_file[W_EVENT] = '0;
						reg_file[W_START] = wdata & ~(SRST_MASK | START_MASK);
						busy = 1'b0;
					end else if ((wdata & START_MASK) != '0) begin
						// stride beats the cycle width, capture lines beat the cycle lines
						w = {1'b0, reg_file[W_STRIDE][12:0]};
						h = {2'b00, reg_file[W_CWIDTH][27:16]};
						if (w == '0)
							w = reg_file[W_CYCLE][13:0];
						if (h == '0)
							h = reg_file[W_CYCLE][29:16];
						if (w != '0 && h != '0 && reg_file[W_DEST] != '0) begin
							width  = (w > MAX_LINE_BYTES_DEF) ? 14'(MAX_LINE_BYTES_DEF) : w;
							height = (h > MAX_LINES_DEF) ? 13'(MAX_LINES_DEF) : 13'(h);
							base   = reg_file[W_DEST];
							col    = '0;
							line   = '0;
							busy   = 1'b1;
						end
					end
				end
			end
			KIND_TICK: begin
				if (busy) begin
					addr = 64'(base) + 64'(line) * 64'(width) + 64'(col);
					r.mem_valid = 1'b1;
					r.mem_addr  = addr[32:0];
					r.mem_byte  = 8'(col + 14'(line));
					col = col + 14'd1;
					if (col >= width) begin
						col  = '0;
						line = line + 13'd1;
						if (line >= height) begin
							reg_file[W_EVENT] = reg_file[W_EVENT] | FRAME_END_MASK;
							reg_file[W_COUNT] = 32'(width) * 32'(height);
							reg_file[W_START] = reg_file[W_START] & ~START_MASK;
							busy = 1'b0;
							line = '0;
							r.frame_done = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string field, input logic [32:0] want_v,
			input logic [32:0] got_v);
		if (got_v !== want_v) begin
			err_cnt++;
			if (err_cnt <= REPORT_CAP)
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
					$time, field, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (reg_file[i])
				reg_file[i] = '0;
			busy      = 1'b0;
			col       = '0;
			line      = '0;
			width     = '0;
			height    = '0;
			base      = '0;
			due_results.delete();
			err_cnt   = 0;
			frame_cnt = 0;
			errors  <= 0;
			pending <= 0;
			frames  <= 0;
		end else begin
			// retire first: a response never belongs to a request of the same edge
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					err_cnt++;
					if (err_cnt <= REPORT_CAP)
						$display("%0t: unexpected response, expected none, got rdata 0x%0h",
							$time, rsp.rdata);
				end else begin
					head = due_results.pop_front();
					check_field("rdata", 33'(head.rdata), 33'(rsp.rdata));
					check_field("mem_valid", 33'(head.mem_valid), 33'(rsp.mem_valid));
					check_field("mem_addr", head.mem_addr, rsp.mem_addr);
					check_field("mem_byte", 33'(head.mem_byte), 33'(rsp.mem_byte));
					check_field("frame_done", 33'(head.frame_done), 33'(rsp.frame_done));
				end
			end
			if (req.valid && req.ready) begin
				fresh = predict_result(req.kind, req.offset, req.wdata);
				if (fresh.frame_done)
					frame_cnt++;
				due_results.push_back(fresh);
			end
			errors  <= err_cnt;
			pending <= due_results.size();
			frames  <= frame_cnt;
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Top of the capture register block testbench: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict. Depends on cupd_pkg, cupd_if and capture_checker.
`timescale 1ns / 1ps

module testbench;
	import cupd_pkg::*;

	// the spare request code the block must ignore
	localparam logic [1:0] KIND_SPARE = 2'd3;
	// cycles without any transfer before the run is declared hung
	localparam int STALL_LIMIT = 5000;
	// counted requests per idling phase
	localparam int PHASE_ITEMS = 410;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int stall_cycles = 0;
	int errors;
	int pending;
	int frames;
	int n_read = 0;
	int n_write = 0;
	int n_tick = 0;
	int n_spare = 0;

	cupd_req_if req_ch ();
	cupd_rsp_if rsp_ch ();

	capture_unit_pattern_dma_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	capture_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (errors),
		.pending (pending),
		.frames  (frames)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Response back-pressure: redraw ready on every edge at the current idle rate.
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Watchdog: any transfer on either channel counts as progress.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog, no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Present one request and hold it until the transfer happens. Sender gaps come
	// first, so valid is either lowered or kept high in any one step, never both.
	task automatic send(input logic [1:0] kind, input logic [7:0] offset,
			input logic [31:0] wdata);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.kind   <= kind;
		req_ch.offset <= offset;
		req_ch.wdata  <= wdata;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		case (kind)
			KIND_READ:  n_read++;
			KIND_WRITE: n_write++;
			KIND_TICK:  n_tick++;
			default:    n_spare++;
		endcase
	endtask

	// Byte offset of a word with random low bits, which the block must ignore.
	function automatic logic [7:0] reg_offset(input logic [REG_AW-1:0] word);
		return {word, 2'($urandom_range(3))};
	endfunction

	task automatic wr_reg(input logic [REG_AW-1:0] word, input logic [31:0] data);
		send(KIND_WRITE, reg_offset(word), data);
	endtask

	task automatic rd_reg(input logic [REG_AW-1:0] word);
		send(KIND_READ, reg_offset(word), $urandom());
	endtask

	// Capture ticks carry random offset and data, which must not matter.
	task automatic ticks(input int n);
		repeat (n)
			send(KIND_TICK, 8'($urandom()), $urandom());
	endtask

	// Hold the sender off until every predicted response has been seen.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// A well-formed frame: small geometry through either register path, a start,
	// then exactly enough ticks, sprinkled with reads, writes while busy, restarts
	// and the odd soft-reset abort. Finish with a look at the end-of-frame words.
	task automatic run_frame();
		logic [12:0] stride;
		logic [11:0] lines;
		logic [13:0] cyc_w;
		logic [13:0] cyc_h;
		logic [31:0] dest;
		int w;
		int h;
		int k;
		stride = $urandom_range(1) ? 13'($urandom_range(1, 6)) : 13'd0;
		lines  = $urandom_range(1) ? 12'($urandom_range(1, 4)) : 12'd0;
		// the cycle fields are only small where they actually set the geometry
		cyc_w  = (stride != '0) ? 14'($urandom()) : 14'($urandom_range(1, 6));
		cyc_h  = (lines != '0) ? 14'($urandom()) : 14'($urandom_range(1, 4));
		if ($urandom_range(3) == 0)
			dest = 32'hFFFF_FFF0 | 32'($urandom_range(15));
		else
			dest = $urandom();
		if (dest == '0)
			dest = 32'h1;
		w = (stride != '0) ? int'(stride) : int'(cyc_w);
		h = (lines != '0) ? int'(lines) : int'(cyc_h);
		wr_reg(W_STRIDE, {19'($urandom()), stride});
		wr_reg(W_CWIDTH, {4'($urandom()), lines, 16'($urandom())});
		wr_reg(W_CYCLE, {2'($urandom()), cyc_h, 2'($urandom()), cyc_w});
		wr_reg(W_DEST, dest);
		if ($urandom_range(3) == 0)
			wr_reg(W_EVENT, '0);
		wr_reg(W_START, ($urandom() & ~SRST_MASK) | START_MASK);
		for (k = 0; k < w * h; k++) begin
			case ($urandom_range(19))
				0: rd_reg(REG_AW'($urandom()));
				1: wr_reg($urandom_range(1) ? W_DEST : W_STRIDE, $urandom());
				2: begin
					if ($urandom_range(3) == 0) begin
						wr_reg(W_START, $urandom() | SRST_MASK);
						break;
					end
				end
				3: begin
					if ($urandom_range(1) == 0)
						wr_reg(W_START, ($urandom() & ~SRST_MASK) | START_MASK);
				end
				default: ;
			endcase
			ticks(1);
		end
		rd_reg(W_EVENT);
		rd_reg(W_COUNT);
		if ($urandom_range(1) == 0)
			rd_reg(W_START);
	endtask

	// A start that must not take: zero destination, zero width or zero line count.
	task automatic run_broken();
		case ($urandom_range(2))
			0: wr_reg(W_DEST, '0);
			1: begin
				wr_reg(W_STRIDE, {19'($urandom()), 13'd0});
				wr_reg(W_CYCLE, {18'($urandom()), 14'd0});
			end
			default: begin
				wr_reg(W_CWIDTH, {4'($urandom()), 12'd0, 16'($urandom())});
				wr_reg(W_CYCLE, {2'($urandom()), 14'd0, 16'($urandom())});
			end
		endcase
		wr_reg(W_START, ($urandom() & ~SRST_MASK) | START_MASK);
		ticks($urandom_range(1, 4));
	endtask

	// Anything at all: every kind, every offset, every data bit.
	task automatic run_noise();
		repeat ($urandom_range(1, 6))
			send(2'($urandom()), 8'($urandom()), $urandom());
	endtask

	initial begin
		int phase;
		int mark;
		int pick;
		req_ch.valid  <= 1'b0;
		req_ch.kind   <= KIND_READ;
		req_ch.offset <= '0;
		req_ch.wdata  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle_pct = 18;
		rx_idle_pct <= 60;
		@(posedge clk);

		// Directed part. Status reads zero whatever was stored there.
		send(KIND_WRITE, {W_STATUS, 2'b10}, 32'hFFFF_FFFF);
		send(KIND_READ, {W_STATUS, 2'b01}, '0);
		// spare kind and the top word of the window, then a tick with nothing running
		send(KIND_SPARE, 8'hFF, 32'hFFFF_FFFF);
		send(KIND_READ, 8'hFF, '0);
		send(KIND_TICK, 8'h00, '0);
		// 2x2 geometry but no destination yet: the start must not take
		wr_reg(W_STRIDE, 32'd2);
		wr_reg(W_CWIDTH, 32'h0002_0000);
		wr_reg(W_START, START_MASK);
		ticks(1);
		// destination at the very top so addresses carry into bit 32
		send(KIND_WRITE, {W_DEST, 2'b11}, 32'hFFFF_FFFF);
		wr_reg(W_START, START_MASK);
		ticks(4);
		rd_reg(W_EVENT);
		rd_reg(W_COUNT);
		// geometry from the cycle word, both fields past the clamps
		wr_reg(W_STRIDE, '0);
		wr_reg(W_CWIDTH, '0);
		wr_reg(W_CYCLE, 32'h3FFF_3FFF);
		wr_reg(W_START, ~SRST_MASK);
		ticks(1);
		// restart while busy, then abort with a soft reset
		wr_reg(W_START, START_MASK);
		ticks(1);
		wr_reg(W_START, 32'hFFFF_FFFF);
		rd_reg(W_START);
		ticks(1);
		drain();

		// Random part in three idling phases; drain between them.
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 18;
					rx_idle_pct <= 60;
				end
				1: begin
					tx_idle_pct = 60;
					rx_idle_pct <= 18;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct <= 0;
				end
			endcase
			mark = n_read + n_write + n_tick;
			while (n_read + n_write + n_tick - mark < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 70)
					run_frame();
				else if (pick < 85)
					run_noise();
				else
					run_broken();
			end
			drain();
		end

		// Clamped geometry from the cycle word at full rate: walk into the first
		// line, then drop the capture with a soft reset and look at the words.
		wr_reg(W_STRIDE, '0);
		wr_reg(W_CWIDTH, '0);
		wr_reg(W_CYCLE, 32'h3FFF_3FFF);
		wr_reg(W_DEST, $urandom() | 32'h1);
		wr_reg(W_START, START_MASK);
		ticks(16);
		wr_reg(W_START, SRST_MASK);
		rd_reg(W_START);
		rd_reg(W_EVENT);
		ticks(2);

		drain();
		repeat (8) @(posedge clk);
		$display("Run covered %0d reads, %0d writes, %0d capture ticks, %0d spare-kind requests;",
			n_read, n_write, n_tick, n_spare);
		$display("%0d frames completed, clamped starts and soft-reset aborts included.", frames);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
